// ===== hdl/sorted_process_queue_defines.svh =====
// Assertion macros shared by the checkers of the sorted process queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SORTED_PROCESS_QUEUE_DEFINES_SVH
`define SORTED_PROCESS_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SPQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ACT_W  = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;
    localparam int KEY_W  = 16;

    typedef enum logic [1:0] {
        ACT_SORT   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_POP    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One queue entry, process id in the low bits.
    typedef struct packed {
        logic [9:0]  mem_handle;
        logic [15:0] time_left;
        logic [7:0]  prio;
        logic [15:0] proc_id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // Result item layout in m_tdata.
    localparam int O_STATUS_LSB = 0;
    localparam int O_ENTRY_LSB  = O_STATUS_LSB + ST_W;
    localparam int O_EMPTY_BIT  = O_ENTRY_LSB + ENTRY_W;
    localparam int O_OCC_LSB    = O_EMPTY_BIT + 1;
    localparam int O_PAD_W      = M_TDATA_W - O_OCC_LSB - OCC_W;

    // Controller to datapath.
    typedef struct packed {
        logic    load;
        logic    rd_next;
        logic    scan_step;
        logic    place;
        logic    append;
        logic    pop;
        logic    finish;
        status_t status;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             empty;
        logic             scan_end;
        logic             out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/spq_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_dpath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [spq_pkg::ACT_W-1:0]       s_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    input  spq_pkg::cmd_t                   cmd,
    output spq_pkg::sts_t                   sts
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W = IDX_W + 1;

    // Circular index: base plus offset, wrapped once.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] sum;
        sum = OFF_W'(base) + off;
        if (sum >= OFF_W'(QUEUE_DEPTH))
        begin
            sum = sum - OFF_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    spq_pkg::entry_t mem [QUEUE_DEPTH];

    logic                         key_mode_reg, key_mode_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         found_reg, found_next;
    logic                         m_valid_reg, m_valid_next;
    spq_pkg::entry_t              item_reg;
    logic [spq_pkg::ACT_W-1:0]    act_reg;
    spq_pkg::entry_t              carry_reg;
    spq_pkg::entry_t              rd_data_reg;
    logic [spq_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                         m_user_reg;

    logic [OFF_W-1:0]             rd_off;
    logic [IDX_W-1:0]             rd_addr;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    spq_pkg::entry_t              wr_data;
    logic [spq_pkg::KEY_W-1:0]    item_key;
    logic [spq_pkg::KEY_W-1:0]    held_key;
    logic                         greater;
    logic                         out_free;
    spq_pkg::entry_t              pop_entry;
    logic [spq_pkg::OCC_W-1:0]    occ;

    assign out_free = !m_valid_reg || m_tready;

    assign item_key = key_mode_reg ? spq_pkg::KEY_W'(item_reg.prio) : item_reg.time_left;
    assign held_key = key_mode_reg ? spq_pkg::KEY_W'(rd_data_reg.prio)
                                   : rd_data_reg.time_left;
    assign greater  = held_key > item_key;

    assign rd_off  = cmd.rd_next ? (OFF_W'(idx_reg) + OFF_W'(1)) : OFF_W'(idx_reg);
    assign rd_addr = phys(head_reg, rd_off);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = phys(head_reg, OFF_W'(idx_reg));
        wr_data = item_reg;
        if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_addr = phys(head_reg, OFF_W'(cnt_reg));
        end
        else if (cmd.place)
        begin
            wr_en   = 1'b1;
            wr_data = found_reg ? carry_reg : item_reg;
        end
        else if (cmd.scan_step)
        begin
            // Once the slot is found, ripple the displaced entries one place back.
            if (found_reg)
            begin
                wr_en   = 1'b1;
                wr_data = carry_reg;
            end
            else if (greater)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.append || cmd.place)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        key_mode_next = cfg_valid ? cfg_data : key_mode_reg;
        head_next     = cmd.pop ? phys(head_reg, OFF_W'(1)) : head_reg;

        idx_next = idx_reg;
        if (cmd.load || cmd.place)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        found_next = found_reg;
        if (cmd.load)
        begin
            found_next = 1'b0;
        end
        else if (cmd.scan_step && greater)
        begin
            found_next = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign pop_entry = cmd.pop ? rd_data_reg : '0;
    assign occ       = spq_pkg::OCC_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg <= 1'b1;
            head_reg     <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            key_mode_reg <= key_mode_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= spq_pkg::entry_t'(s_tdata[spq_pkg::ENTRY_W-1:0]);
            act_reg  <= s_tuser;
        end
        if (cmd.scan_step && (found_reg || greater))
        begin
            carry_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            m_data_reg <= {{spq_pkg::O_PAD_W{1'b0}}, occ, (cnt_next == '0),
                           pop_entry, cmd.status};
            m_user_reg <= cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign sts.act      = act_reg;
    assign sts.full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.empty    = (cnt_reg == '0);
    assign sts.scan_end = (CNT_W'(idx_reg) == cnt_reg);
    assign sts.out_free = out_free;

endmodule

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.status = spq_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.act)
                    spq_pkg::ACT_SORT:
                    begin
                        if (!sts.full)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = spq_pkg::ST_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    spq_pkg::ACT_APPEND:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.finish = 1'b1;
                            if (sts.full)
                            begin
                                cmd.status = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    spq_pkg::ACT_POP:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.finish = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.status = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // Unused action: report ok, touch nothing.
                        if (sts.out_free)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.rd_next = 1'b1;
                if (!sts.scan_end)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.place  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sorted_process_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted process queue. Holds up to QUEUE_DEPTH process entries (id, priority,
// remaining time, memory handle) in a circular buffer memory, head first. Each
// input item carries an action in s_tuser: sorted insert places the entry after
// every held entry whose key is less than or equal to its own, counted from the
// head; append puts it at the tail; pop removes and returns the head. The key is
// the priority when key_mode (written through cfg_valid/cfg_data, reset 1) is 1,
// the remaining time when it is 0. Every item gives exactly one result item.
// Append, pop and refused actions load the result register from the execute
// state that follows the accept; a sorted insert goes on from there to walk the
// memory one entry per cycle through its single read port, shifting the entries
// behind the insertion point back by one as it goes, and loads the result
// register when the walk ends. One item is processed at a time; the next item is
// accepted as soon as the previous one has moved into the output register, even
// while that result still waits for m_tready. Configuration is to be written by
// the user only while no item is in flight; the block itself does not enforce it.
module sorted_process_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // proc_id[15:0], prio_in[23:16], time_left_in[39:24], mem_handle_in[49:40]
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [spq_pkg::ACT_W-1:0]       s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], proc_id_out[17:2], prio_out[25:18], time_left_out[41:26],
    // mem_handle_out[51:42], queue_empty[52], occupancy[57:53]
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    // popped_valid[0]
    output logic                            m_tuser,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    // key_mode
    input  logic                            cfg_data
);

    spq_pkg::cmd_t cmd;
    spq_pkg::sts_t sts;

    // The key register is always free to take a write.
    assign cfg_ready = 1'b1;

    // Sequencer: dispatch the action, walk the entries, hold on a full output.
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Entry memory, pointers, compare and the result register.
    spq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_process_queue_defines.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    logic [spq_pkg::ST_W-1:0]  status;
    logic [spq_pkg::OCC_W-1:0] occ;
    logic                      empty;

    assign status = m_tdata[spq_pkg::O_STATUS_LSB +: spq_pkg::ST_W];
    assign occ    = m_tdata[spq_pkg::O_OCC_LSB +: spq_pkg::OCC_W];
    assign empty  = m_tdata[spq_pkg::O_EMPTY_BIT];

    `SPQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `SPQ_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    `SPQ_ASSERT_IMP(a_empty_occ, m_tvalid && empty, occ == '0, "empty queue with nonzero occupancy")
    `SPQ_ASSERT_IMP(a_pop_ok, m_tvalid && m_tuser, status == spq_pkg::ST_OK, "popped entry with error status")
    `SPQ_ASSERT_IMP(a_full_count, m_tvalid && (status == spq_pkg::ST_FULL), !m_tuser && (occ == spq_pkg::OCC_W'(QUEUE_DEPTH)), "refused insert on a queue that is not full")

endmodule

bind sorted_process_queue spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = spq_pkg::QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
    localparam int SETTLE_CYC  = DEPTH + 8;
    localparam int CHUNK       = 40;
    localparam int PHASE_ITEMS = 208;

    // Action code 3 is not in the package enum; the block must treat it as a no-op.
    localparam logic [spq_pkg::ACT_W-1:0] ACT_NOP = 2'd3;

    // One pending input item: the action and the entry it carries.
    typedef struct {
        logic [spq_pkg::ACT_W-1:0] act;
        spq_pkg::entry_t           ent;
    } sched_req_t;

    // One expected result item.
    typedef struct {
        spq_pkg::status_t          status;
        logic                      popped;
        spq_pkg::entry_t           ent;
        logic                      empty;
        logic [spq_pkg::OCC_W-1:0] occ;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [spq_pkg::ACT_W-1:0]     s_tuser = '0;

    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    // Stimulus and scoreboard storage.
    sched_req_t    sched_reqs[$];
    sched_result_t exp_results[$];

    // Shadow copy of the queue contents and the sort key selection.
    spq_pkg::entry_t mdl_entries[DEPTH];
    int              mdl_count = 0;
    logic            mdl_key_prio = 1'b1;

    int   mismatches = 0;
    int   in_count = 0;
    int   out_count = 0;
    int   cfg_writes = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic s_took = 1'b0;

    sorted_process_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Queue predictor
    // ------------------------------------------------------------------

    // Key used for sorting: priority in priority mode, remaining time otherwise.
    function automatic logic [15:0] sort_key(spq_pkg::entry_t e);
        return mdl_key_prio ? {8'h00, e.prio} : e.time_left;
    endfunction

    // Apply one action to the shadow queue and return the result it gives.
    function automatic sched_result_t queue_model_step(logic [spq_pkg::ACT_W-1:0] act,
                                                       spq_pkg::entry_t ent);
        sched_result_t r;
        int            pos;
        r.status = spq_pkg::ST_OK;
        r.popped = 1'b0;
        r.ent    = '0;
        if (act == spq_pkg::ACT_SORT || act == spq_pkg::ACT_APPEND)
        begin
            if (mdl_count >= DEPTH)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                pos = mdl_count;
                // Sorted insert goes in front of the first entry with a strictly
                // larger key, so equal keys keep arrival order.
                if (act == spq_pkg::ACT_SORT)
                begin
                    for (int i = 0; i < mdl_count; i++)
                    begin
                        if (sort_key(mdl_entries[i]) > sort_key(ent))
                        begin
                            pos = i;
                            break;
                        end
                    end
                end
                for (int i = mdl_count; i > pos; i--)
                    mdl_entries[i] = mdl_entries[i - 1];
                mdl_entries[pos] = ent;
                mdl_count++;
            end
        end
        else if (act == spq_pkg::ACT_POP)
        begin
            if (mdl_count == 0)
                r.status = spq_pkg::ST_EMPTY;
            else
            begin
                r.popped = 1'b1;
                r.ent    = mdl_entries[0];
                for (int i = 1; i < mdl_count; i++)
                    mdl_entries[i - 1] = mdl_entries[i];
                mdl_count--;
            end
        end
        r.empty = (mdl_count == 0);
        r.occ   = mdl_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_result_t   want;
        spq_pkg::entry_t got_ent;
        s_took <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                mdl_key_prio = cfg_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                exp_results.push_back(queue_model_step(s_tuser,
                    spq_pkg::entry_t'(s_tdata[spq_pkg::ENTRY_W-1:0])));
                in_count++;
            end
            if (m_tvalid && m_tready)
            begin
                out_count++;
                if (exp_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result item 0x%0h", $time, m_tdata);
                end
                else
                begin
                    want    = exp_results.pop_front();
                    got_ent = spq_pkg::entry_t'(
                        m_tdata[spq_pkg::O_ENTRY_LSB +: spq_pkg::ENTRY_W]);
                    check_field("status", want.status,
                                m_tdata[spq_pkg::O_STATUS_LSB +: spq_pkg::ST_W]);
                    check_field("popped_valid", want.popped, m_tuser);
                    check_field("proc_id_out", want.ent.proc_id, got_ent.proc_id);
                    check_field("prio_out", want.ent.prio, got_ent.prio);
                    check_field("time_left_out", want.ent.time_left, got_ent.time_left);
                    check_field("mem_handle_out", want.ent.mem_handle, got_ent.mem_handle);
                    check_field("queue_empty", want.empty, m_tdata[spq_pkg::O_EMPTY_BIT]);
                    check_field("occupancy", want.occ,
                                m_tdata[spq_pkg::O_OCC_LSB +: spq_pkg::OCC_W]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input driver: hold an offered item until accepted, then advance.
    // Insert random gaps, except in a calm window where it streams back to back.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        sched_req_t nxt;
        logic       gap;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            gap = (in_count < 600 || in_count >= 760) && ($urandom_range(99) < 11);
            if (sched_reqs.size() > 0 && !gap)
            begin
                nxt = sched_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.act;
                s_tdata  <= {{(spq_pkg::S_TDATA_W - spq_pkg::ENTRY_W){1'b0}}, nxt.ent};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output backpressure: random stalls, one long hold-off to fill the block
    // and stall its input, and a calm window with no stalls.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && out_count >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= 250;
            m_tready  <= 1'b0;
        end
        else if (out_count >= 600 && out_count < 760)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 11);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[sorted_process_queue] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic [spq_pkg::ACT_W-1:0] act, logic [15:0] id, logic [7:0] pr,
                            logic [15:0] tl, logic [9:0] mem);
        sched_req_t q;
        q.act                = act;
        q.ent.proc_id        = id;
        q.ent.prio           = pr;
        q.ent.time_left      = tl;
        q.ent.mem_handle     = mem;
        sched_reqs.push_back(q);
    endtask

    // Queue one random item; ins_pct sets how often it inserts rather than pops.
    // Half the items draw keys from a tiny range to force ties.
    task automatic add_random(int ins_pct);
        int                        r;
        logic [spq_pkg::ACT_W-1:0] act;
        r = $urandom_range(99);
        if (r < 2)
            act = ACT_NOP;
        else if (r < 2 + ins_pct)
            act = ($urandom_range(3) == 0) ? spq_pkg::ACT_APPEND : spq_pkg::ACT_SORT;
        else
            act = spq_pkg::ACT_POP;
        if ($urandom_range(1))
            add_item(act, 16'($urandom), 8'($urandom_range(7)), 16'($urandom_range(7)),
                     10'($urandom));
        else
            add_item(act, 16'($urandom), 8'($urandom), 16'($urandom), 10'($urandom));
    endtask

    // Wait until every item is accepted and every result has come back,
    // then let the block drain its pipeline.
    task automatic settle();
        while (sched_reqs.size() > 0 || s_tvalid || exp_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_key_mode(logic mode);
        int target;
        target = cfg_writes + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        while (cfg_writes != target)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: chunks of varying insert/pop mix so the queue swings
    // between empty and full.
    task automatic random_phase(int n);
        int pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % CHUNK == 0)
            begin
                case ($urandom_range(2))
                    0: pct = 25;
                    1: pct = 50;
                    default: pct = 80;
                endcase
            end
            add_random(pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, priority key from reset.
        add_item(spq_pkg::ACT_POP, 16'h0000, 8'h00, 16'h0000, 10'h000);      // pop on empty
        add_item(ACT_NOP, 16'hFFFF, 8'hFF, 16'hFFFF, 10'h3FF);               // unused code
        add_item(spq_pkg::ACT_SORT, 16'hFFFF, 8'h80, 16'hFFFF, 10'h3FF);
        add_item(spq_pkg::ACT_SORT, 16'h0000, 8'h80, 16'h0000, 10'h000);     // tie, behind
        add_item(spq_pkg::ACT_SORT, 16'h0001, 8'h00, 16'h1234, 10'h155);     // new head
        add_item(spq_pkg::ACT_SORT, 16'h0002, 8'hFF, 16'h8000, 10'h2AA);     // new tail
        add_item(spq_pkg::ACT_APPEND, 16'h0003, 8'h00, 16'h0001, 10'h001);   // breaks order
        add_item(spq_pkg::ACT_SORT, 16'h0004, 8'h7F, 16'h7FFF, 10'h200);     // unsorted
        // Fill to the brim with appends.
        for (int i = 0; i < DEPTH - 6; i++)
            add_item(spq_pkg::ACT_APPEND, 16'($urandom), 8'($urandom), 16'($urandom),
                     10'($urandom));
        add_item(spq_pkg::ACT_SORT, 16'hAAAA, 8'h00, 16'h0000, 10'h0AA);     // insert full
        add_item(spq_pkg::ACT_APPEND, 16'h5555, 8'hFF, 16'hFFFF, 10'h355);   // append full
        add_item(ACT_NOP, 16'h0000, 8'h00, 16'h0000, 10'h000);
        add_item(spq_pkg::ACT_POP, 16'h0000, 8'h00, 16'h0000, 10'h000);
        add_item(spq_pkg::ACT_POP, 16'h0000, 8'h00, 16'h0000, 10'h000);
        settle();

        // Random part: alternate the key, leaving the queue contents in place
        // across each switch so inserts also land in unsorted queues.
        write_key_mode(1'b0);
        random_phase(PHASE_ITEMS);
        settle();
        write_key_mode(1'b1);
        random_phase(PHASE_ITEMS);
        settle();
        write_key_mode(1'b0);
        random_phase(PHASE_ITEMS);
        settle();
        write_key_mode(1'b1);
        random_phase(PHASE_ITEMS);
        settle();
        write_key_mode(1'b0);
        random_phase(PHASE_ITEMS);
        settle();

        if (mismatches == 0)
            $display("[sorted_process_queue] OK");
        else
            $display("[sorted_process_queue] ERROR");
        $finish;
    end

endmodule
